### src/i64a_pkg.sv
package i64a_pkg;

  // Width of the converted value; bits of the input value above it are ignored.
  localparam int VALUE_BITS = 64;
  localparam int CNT_W      = $clog2(VALUE_BITS);

  // Twenty decimal digits hold any 64-bit magnitude.
  localparam int NUM_DIGITS = 20;
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic        func;
    logic [63:0] value;
  } in_word_t;

  typedef struct packed {
    logic [5:0] ascii_char;
    logic       last;
  } out_word_t;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

endpackage

### src/i64a_dabble.sv
module i64a_dabble import i64a_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] mag,
  output dab_stat_t             stat,
  output bcd_t                  bcd
);

  logic [VALUE_BITS-1:0]   bin_r, bin_nxt;
  bcd_t                    bcd_r, bcd_nxt;
  bcd_t                    adj;
  logic [NUM_DIGITS*4-1:0] adj_bits;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  // Add three to every digit of five or more before the shift, so that the
  // doubling carries correctly into the next decimal place.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  // The shift runs over single bits, not over whole digits.
  assign adj_bits = adj;

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {adj_bits[NUM_DIGITS*4-2:0], bin_r[VALUE_BITS-1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

### src/int64_to_decimal_ascii_core.sv
// Converts one 64-bit value per word, unsigned or two's-complement signed as
// func selects, into its decimal text: an optional '-' and then the digits,
// most significant first, with no leading zeros, one character per output
// word and last set on the final one. The block takes one word at a time:
// a shift-and-add-three binary to BCD unit works through the value bit by
// bit, the digit register is then loaded from it, and its digits are shifted
// out one per cycle while the output side does not stall, after a sign if
// the value is negative. Output stalls hold the digit shift, but leading
// zeros are shifted away even during a stall.
module int64_to_decimal_ascii_core import i64a_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CONV  = 2'd1;
  localparam logic [1:0] S_SIGN  = 2'd2;
  localparam logic [1:0] S_DIGIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic             neg_r, neg_nxt;
  bcd_t             dig_r, dig_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             lead_r, lead_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic                  in_acc;
  logic                  can_load;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  dab_stat_t             dab_stat;
  bcd_t                  dab_bcd;
  logic [3:0]            top;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;

  assign raw    = in_word.value[VALUE_BITS-1:0];
  assign neg_in = in_word.func && raw[VALUE_BITS-1];
  assign mag    = neg_in ? (~raw + 1'b1) : raw;
  assign top    = dig_r[NUM_DIGITS-1];

  i64a_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .mag   (mag),
    .stat  (dab_stat),
    .bcd   (dab_bcd)
  );

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    dig_nxt       = dig_r;
    rem_nxt       = rem_r;
    lead_nxt      = lead_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt   = neg_in;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (dab_stat.done) begin
          dig_nxt   = dab_bcd;
          rem_nxt   = REM_W'(NUM_DIGITS);
          lead_nxt  = 1'b1;
          state_nxt = neg_r ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (can_load) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.ascii_char = CHAR_MINUS;
          out_word_nxt.last       = 1'b0;
          state_nxt               = S_DIGIT;
        end
      end
      S_DIGIT: begin
        // Leading zeros are shifted away silently; the units digit always
        // goes out, so zero still gives one character.
        if (lead_r && top == 4'd0 && rem_r != REM_W'(1)) begin
          dig_nxt = {dig_r[NUM_DIGITS-2:0], 4'd0};
          rem_nxt = rem_r - 1'b1;
        end else if (can_load) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.ascii_char = CHAR_ZERO + {2'b00, top};
          out_word_nxt.last       = (rem_r == REM_W'(1));
          dig_nxt                 = {dig_r[NUM_DIGITS-2:0], 4'd0};
          rem_nxt                 = rem_r - 1'b1;
          lead_nxt                = 1'b0;
          if (rem_r == REM_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    dig_r      <= dig_nxt;
    rem_r      <= rem_nxt;
    lead_r     <= lead_nxt;
    out_word_r <= out_word_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> dab_stat.busy)
    else $error("conversion did not start after an accepted word");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !dab_stat.busy)
    else $error("input ready while conversion is running");

  a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIGN) |-> neg_r)
    else $error("sign emitted for a non-negative value");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.ascii_char == CHAR_MINUS ||
                     (out_word_r.ascii_char >= CHAR_ZERO &&
                      out_word_r.ascii_char <= CHAR_ZERO + 6'd9)))
    else $error("output character is not a digit or minus");

endmodule
